// ===== sv/pcgbr_pkg.sv =====
`timescale 1ns / 1ps
package pcgbr_pkg;

  localparam logic [63:0] LcgMult   = 64'd6364136223846793005;
  localparam logic [63:0] StateInit = 64'h853c49e6748fea9b;
  localparam logic [63:0] IncInit   = 64'hda3e39cb94b95bdb;

  localparam int DivSteps = 32;
  localparam int DivCntW  = $clog2(DivSteps);

  localparam logic CmdReseed = 1'b0;
  localparam logic CmdDraw   = 1'b1;

  localparam logic CfgSeed   = 1'b0;
  localparam logic CfgStream = 1'b1;

  typedef enum logic [1:0] {
    MUL_LL = 2'b00,
    MUL_LH = 2'b01,
    MUL_HL = 2'b10
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     rs_init;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     inc_add;
    logic     seed_add;
    logic     div_init_thr;
    logic     div_init_mod;
    logic     div_run;
    logic     done;
  } dp_cmd_t;

  typedef struct packed {
    logic is_draw;
    logic bound_zero;
    logic accept;
    logic div_last;
  } dp_status_t;

  // XSH-RR output from the pre-step state
  function automatic logic [31:0] xsh_rr(input logic [63:0] s);
    logic [63:0] x;
    logic [31:0] mixed;
    logic [4:0]  rot;
    logic [63:0] dbl;
    x     = (s >> 18) ^ s;
    mixed = x[58:27];
    rot   = s[63:59];
    dbl   = {mixed, mixed} >> rot;
    return dbl[31:0];
  endfunction

endpackage

// ===== sv/pcgbr_ctrl.sv =====
`timescale 1ns / 1ps
module pcgbr_ctrl
  import pcgbr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_LOAD    = 13'b0000000000010,
    S_RS_INIT = 13'b0000000000100,
    S_STEP_A  = 13'b0000000001000,
    S_STEP_B  = 13'b0000000010000,
    S_STEP_C  = 13'b0000000100000,
    S_STEP_D  = 13'b0000001000000,
    S_SEED    = 13'b0000010000000,
    S_DIV_T   = 13'b0000100000000,
    S_CHECK   = 13'b0001000000000,
    S_DIV_M   = 13'b0010000000000,
    S_DONE    = 13'b0100000000000,
    S_SPARE   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   seeded_q, seeded_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      seeded_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      seeded_q <= seeded_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    seeded_d = seeded_q;
    cmd_o    = '0;
    cmd_o.mul_sel = MUL_LL;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOAD;
        end
      end
      S_LOAD: begin
        seeded_d = 1'b0;
        if (!status_i.is_draw) begin
          state_d = S_RS_INIT;
        end else if (status_i.bound_zero) begin
          state_d = S_STEP_A;
        end else begin
          cmd_o.div_init_thr = 1'b1;
          state_d            = S_DIV_T;
        end
      end
      S_RS_INIT: begin
        cmd_o.rs_init = 1'b1;
        state_d       = S_STEP_A;
      end
      S_STEP_A: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LL;
        state_d       = S_STEP_B;
      end
      S_STEP_B: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LH;
        state_d       = S_STEP_C;
      end
      S_STEP_C: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_HL;
        state_d       = S_STEP_D;
      end
      S_STEP_D: begin
        cmd_o.inc_add = 1'b1;
        if (!status_i.is_draw) begin
          state_d = seeded_q ? S_DONE : S_SEED;
        end else if (status_i.bound_zero) begin
          state_d = S_DONE;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_SEED: begin
        cmd_o.seed_add = 1'b1;
        seeded_d       = 1'b1;
        state_d        = S_STEP_A;
      end
      S_DIV_T: begin
        cmd_o.div_run = 1'b1;
        if (status_i.div_last) begin
          state_d = S_STEP_A;
        end
      end
      S_CHECK: begin
        if (status_i.accept) begin
          cmd_o.div_init_mod = 1'b1;
          state_d            = S_DIV_M;
        end else begin
          state_d = S_STEP_A;
        end
      end
      S_DIV_M: begin
        cmd_o.div_run = 1'b1;
        if (status_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.done = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/pcgbr_dp.sv =====
`timescale 1ns / 1ps
module pcgbr_dp
  import pcgbr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_i,
  input  logic [31:0] bound_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  dp_cmd_t     cmd_in_i,
  output dp_status_t  status_o,
  output logic        valid_o,
  output logic [31:0] value_o
);

  logic [63:0] state_q, inc_q, seed_q;
  logic [62:0] stream_q;
  logic        cmd_q;
  logic [31:0] bound_q;
  logic [63:0] acc_q;
  logic [31:0] rnd_q;
  logic [31:0] rem_q, dvd_q;
  logic [DivCntW-1:0] cnt_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        fits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      stream_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSeed:   seed_q   <= cfg_data_i;
        CfgStream: stream_q <= cfg_data_i[62:0];
        default:   seed_q   <= seed_q;
      endcase
    end
  end

  always_comb begin
    case (cmd_in_i.mul_sel)
      MUL_LL: begin
        mul_a = state_q[31:0];
        mul_b = LcgMult[31:0];
      end
      MUL_LH: begin
        mul_a = state_q[31:0];
        mul_b = LcgMult[63:32];
      end
      MUL_HL: begin
        mul_a = state_q[63:32];
        mul_b = LcgMult[31:0];
      end
      default: begin
        mul_a = state_q[31:0];
        mul_b = LcgMult[31:0];
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateInit;
      inc_q   <= IncInit;
    end else if (cmd_in_i.rs_init) begin
      state_q <= '0;
      inc_q   <= {stream_q, 1'b1};
    end else if (cmd_in_i.inc_add) begin
      state_q <= acc_q + inc_q;
    end else if (cmd_in_i.seed_add) begin
      state_q <= state_q + seed_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.load) begin
      cmd_q   <= cmd_i;
      bound_q <= bound_i;
    end
    if (cmd_in_i.mul_en) begin
      if (cmd_in_i.mul_sel == MUL_LL) begin
        acc_q <= prod;
        rnd_q <= xsh_rr(state_q);
      end else begin
        acc_q <= acc_q + {prod[31:0], 32'd0};
      end
    end
  end

  // restoring remainder, one bit per cycle
  assign rem_sh  = {rem_q, dvd_q[31]};
  assign fits    = (rem_sh >= {1'b0, bound_q});
  assign rem_sub = rem_sh - {1'b0, bound_q};

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.div_init_thr) begin
      rem_q <= '0;
      dvd_q <= 32'd0 - bound_q;
      cnt_q <= '0;
    end else if (cmd_in_i.div_init_mod) begin
      rem_q <= '0;
      dvd_q <= rnd_q;
      cnt_q <= '0;
    end else if (cmd_in_i.div_run) begin
      rem_q <= fits ? rem_sub[31:0] : rem_sh[31:0];
      dvd_q <= {dvd_q[30:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign status_o.is_draw    = (cmd_q == CmdDraw);
  assign status_o.bound_zero = (bound_q == 32'd0);
  assign status_o.accept     = (rnd_q >= rem_q);
  assign status_o.div_last   = (cnt_q == DivCntW'(DivSteps - 1));

  assign valid_o = cmd_in_i.done;
  always_comb begin
    if (cmd_q == CmdReseed) begin
      value_o = '0;
    end else if (bound_q == 32'd0) begin
      value_o = rnd_q;
    end else begin
      value_o = rem_q;
    end
  end

endmodule

// ===== sv/pcg32_bounded_random.sv =====
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// input     start / busy       cmd_i, bound_i
// result    valid_o (1 cycle)  value_o
// config    cfg_we_i           cfg_idx_i, cfg_data_i
//
// Reseed: zero state, step, add seed, step. Raw draw: step. Bounded draw:
// threshold mod, step until accepted, final mod. One 32x32 multiplier
// does the LCG step in three passes; one bit-serial divider does both
// mods. busy falls the cycle after valid_o. Reset loads the default
// state. The receiver cannot stall; each result shows for one cycle only.
module pcg32_bounded_random
  import pcgbr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [31:0] bound_i,
  output logic        valid_o,
  output logic [31:0] value_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  pcgbr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (dp_status),
    .cmd_o    (dp_cmd)
  );

  pcgbr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .bound_i    (bound_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_in_i   (dp_cmd),
    .status_o   (dp_status),
    .valid_o    (valid_o),
    .value_o    (value_o)
  );

endmodule
